>>> sv/gjm_pkg.sv
// Package for the Gauss-Jordan matrix inverse core.
// Holds the store geometry, the fixed-point constants, the sequencer states
// and the divider result type. It depends on nothing.
`default_nettype none
package gjm_pkg;
    localparam int MAX_ORDER  = 8;
    localparam int STORE_COLS = 2 * MAX_ORDER;
    localparam int STORE_DEPTH = MAX_ORDER * STORE_COLS;
    localparam int ROW_W  = $clog2(MAX_ORDER);
    localparam int COL_W  = $clog2(STORE_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int ORD_W  = ROW_W + 1;
    localparam int K_W    = COL_W + 1;
    localparam int DATA_W = 32;
    localparam int NUM_W  = 48;

    localparam logic [DATA_W-1:0] ONE_Q16  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] Q_MIN    = 32'h8000_0000;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] CFG_PIVOT_THR   = 2'd1;

    localparam int ST_W = 23;
    typedef enum logic [ST_W-1:0] {
        S_LOAD  = 23'b1 << 0,
        S_IDENT = 23'b1 << 1,
        S_PRD   = 23'b1 << 2,
        S_PCHK  = 23'b1 << 3,
        S_SRD   = 23'b1 << 4,
        S_SCHK  = 23'b1 << 5,
        S_W1    = 23'b1 << 6,
        S_W2    = 23'b1 << 7,
        S_W3    = 23'b1 << 8,
        S_W4    = 23'b1 << 9,
        S_NRD   = 23'b1 << 10,
        S_NDIV  = 23'b1 << 11,
        S_NWAIT = 23'b1 << 12,
        S_EROW  = 23'b1 << 13,
        S_ERAT  = 23'b1 << 14,
        S_EK1   = 23'b1 << 15,
        S_EK2   = 23'b1 << 16,
        S_EK3   = 23'b1 << 17,
        S_EK4   = 23'b1 << 18,
        S_ORD   = 23'b1 << 19,
        S_OLAT  = 23'b1 << 20,
        S_OWAIT = 23'b1 << 21,
        S_SING  = 23'b1 << 22
    } t_state;

    // Result of the shared divider, valid while done is high.
    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] quo;
    } t_div_res;

    // Store address of a row and a column.
    function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        store_addr = {row, col};
    endfunction
endpackage
`default_nettype wire

>>> sv/gjm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; used for the augmented store.
`default_nettype none
module gjm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/gjm_div.sv
// Restoring divider for (a * 65536) / d with truncation toward zero and
// saturation to 32 bits. One quotient bit per cycle. Uses gjm_pkg.
`default_nettype none
module gjm_div (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [31:0]           i_num,
    input  wire logic [31:0]           i_den,
    output gjm_pkg::t_div_res          o_res
);
    import gjm_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_neg;
    logic [NUM_W-1:0]  r_num;
    logic [NUM_W-1:0]  r_quo;
    logic [DATA_W:0]   r_rem;
    logic [DATA_W-1:0] r_den;
    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] d_mag;
    logic              pos_sat;
    logic              neg_sat;

    // Operand magnitudes; the magnitude of the most negative value fits 32 bits.
    assign a_mag = i_num[31] ? 32'(-i_num) : i_num;
    assign d_mag = i_den[31] ? 32'(-i_den) : i_den;

    // One restoring step.
    assign rem_sh = {r_rem[DATA_W-1:0], r_num[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_num[31] ^ i_den[31];
            r_num <= {a_mag, 16'h0000};
            r_den <= d_mag;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], ge};
            r_rem <= ge ? 33'(rem_sh - {1'b0, r_den}) : rem_sh;
        end
    end

    // Sign and saturation of the finished quotient.
    assign pos_sat = !r_neg && (r_quo > NUM_W'(Q_MAX));
    assign neg_sat = r_neg && (r_quo > NUM_W'(Q_MIN));

    always_comb begin
        o_res.done = r_done;
        o_res.sat  = pos_sat || neg_sat;
        if (pos_sat) begin
            o_res.quo = Q_MAX;
        end else if (neg_sat) begin
            o_res.quo = Q_MIN;
        end else if (r_neg) begin
            o_res.quo = 32'(-r_quo[DATA_W-1:0]);
        end else begin
            o_res.quo = r_quo[DATA_W-1:0];
        end
    end
endmodule
`default_nettype wire

>>> sv/gauss_jordan_matrix_inverse_core.sv
// Gauss-Jordan matrix inverter, signed Q16.16, with sequencer and datapath.
// Uses gjm_pkg, gjm_ram (augmented store) and gjm_div (shared divider).
// Loading takes one element per cycle while s_axis_tvalid is high; n*n identity writes follow the last one.
// Per pivot: a pivot check, a search of the rows below with a column-by-column swap
// when the pivot is under the threshold, normalization of all 2n row entries by the
// shared divider and elimination of the other n-1 rows. Output waits on m_axis_tready.
// Reset (synchronous, active low) restores size 8, threshold 1, empty load.
`default_nettype none
module gauss_jordan_matrix_inverse_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // element_value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // inverse_value, row_index, col_index, zeros
    output logic             m_axis_tlast,
    output logic [1:0]       m_axis_tuser    // singular, overflow
);
    import gjm_pkg::*;

    t_state             r_state, n_state;
    logic [3:0]         r_size;
    logic [15:0]        r_thr;
    logic [5:0]         r_lc;
    logic               r_sat;
    logic [ORD_W-1:0]   r_i, r_j, r_found;
    logic [K_W-1:0]     r_k;
    logic [DATA_W-1:0]  r_pivot, r_ratio, r_tmp, r_x, r_pq;
    logic [63:0]        r_prod;
    logic               r_m_valid;
    logic [39:0]        r_m_data;
    logic               r_m_last;
    logic [1:0]         r_m_user;

    logic [ORD_W-1:0]   n_use;
    logic [K_W-1:0]     two_n;
    logic [6:0]         total;
    logic [6:0]         lc_eff;
    logic [ROW_W-1:0]   ld_row;
    logic [COL_W-1:0]   ld_col;
    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    logic [DATA_W-1:0]  wdata, rdata;
    logic [32:0]        rd_mag;
    logic [32:0]        thr33;
    logic               div_start;
    t_div_res           div_res;
    logic [47:0]        pq48;
    logic               pq_hi, pq_lo;
    logic [DATA_W-1:0]  pq_sat;
    logic [32:0]        diff;
    logic               d_hi, d_lo;
    logic [DATA_W-1:0]  diff_sat;
    logic               accept;

    // Order in use: zero means 1, above the maximum means the maximum.
    always_comb begin
        if (r_size == 4'd0) begin
            n_use = ORD_W'(1);
        end else if (r_size > 4'(MAX_ORDER)) begin
            n_use = ORD_W'(MAX_ORDER);
        end else begin
            n_use = ORD_W'(r_size);
        end
    end
    assign two_n = {n_use, 1'b0};
    assign total = 7'(n_use * n_use);
    assign lc_eff = ({1'b0, r_lc} >= total) ? 7'd0 : {1'b0, r_lc};

    // Row and column of the loaded element by counting multiples of n.
    always_comb begin
        logic [ROW_W-1:0] cnt;
        cnt = '0;
        for (int m = 1; m < MAX_ORDER; m++) begin
            if (lc_eff >= 7'(m * n_use)) begin
                cnt = cnt + 1'b1;
            end
        end
        ld_row = cnt;
        ld_col = COL_W'(lc_eff - 7'(cnt * n_use));
    end

    assign rd_mag = rdata[31] ? 33'(-{1'b1, rdata}) : {1'b0, rdata};
    assign thr33  = {17'd0, r_thr};

    // Product scaled by 1/65536 with truncation toward zero, then saturated.
    assign pq48  = 48'(r_prod >>> 16) + 48'(r_prod[63] && (r_prod[15:0] != 16'd0));
    assign pq_hi = !pq48[47] && (pq48[46:31] != 16'd0);
    assign pq_lo = pq48[47] && (pq48[46:31] != 16'hFFFF);
    assign pq_sat = pq_hi ? Q_MAX : (pq_lo ? Q_MIN : pq48[31:0]);

    // Saturating subtraction.
    assign diff = {r_x[31], r_x} - {r_pq[31], r_pq};
    assign d_hi = !diff[32] && diff[31];
    assign d_lo = diff[32] && !diff[31];
    assign diff_sat = d_hi ? Q_MAX : (d_lo ? Q_MIN : diff[31:0]);

    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_LOAD);
    assign div_start = (r_state == S_NDIV);

    // Store port selection per state.
    always_comb begin
        we    = 1'b0;
        waddr = '0;
        wdata = rdata;
        raddr = '0;
        case (r_state)
            S_LOAD: begin
                we    = accept;
                waddr = store_addr(ld_row, ld_col);
                wdata = s_axis_tdata;
            end
            S_IDENT: begin
                we    = 1'b1;
                waddr = store_addr(r_i[ROW_W-1:0], COL_W'(n_use + r_j));
                wdata = (r_i == r_j) ? ONE_Q16 : '0;
            end
            S_PRD:   raddr = store_addr(r_i[ROW_W-1:0], COL_W'(r_i));
            S_SRD:   raddr = store_addr(r_j[ROW_W-1:0], COL_W'(r_i));
            S_W1:    raddr = store_addr(r_i[ROW_W-1:0], r_k[COL_W-1:0]);
            S_W2:    raddr = store_addr(r_found[ROW_W-1:0], r_k[COL_W-1:0]);
            S_W3: begin
                we    = 1'b1;
                waddr = store_addr(r_i[ROW_W-1:0], r_k[COL_W-1:0]);
                wdata = rdata;
            end
            S_W4: begin
                we    = 1'b1;
                waddr = store_addr(r_found[ROW_W-1:0], r_k[COL_W-1:0]);
                wdata = r_tmp;
            end
            S_NRD:   raddr = store_addr(r_i[ROW_W-1:0], r_k[COL_W-1:0]);
            S_NWAIT: begin
                we    = div_res.done;
                waddr = store_addr(r_i[ROW_W-1:0], r_k[COL_W-1:0]);
                wdata = div_res.quo;
            end
            S_EROW:  raddr = store_addr(r_j[ROW_W-1:0], COL_W'(r_i));
            S_EK1:   raddr = store_addr(r_i[ROW_W-1:0], r_k[COL_W-1:0]);
            S_EK2:   raddr = store_addr(r_j[ROW_W-1:0], r_k[COL_W-1:0]);
            S_EK4: begin
                we    = 1'b1;
                waddr = store_addr(r_j[ROW_W-1:0], r_k[COL_W-1:0]);
                wdata = diff_sat;
            end
            S_ORD:   raddr = store_addr(r_i[ROW_W-1:0], COL_W'(n_use + r_j));
            default: we = 1'b0;
        endcase
    end

    gjm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    gjm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (rdata),
        .i_den  (r_pivot),
        .o_res  (div_res)
    );

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD:  if (accept && (7'(lc_eff + 7'd1) == total)) n_state = S_IDENT;
            S_IDENT: if (r_i + 1'b1 == n_use && r_j + 1'b1 == n_use) n_state = S_PRD;
            S_PRD:   n_state = S_PCHK;
            S_PCHK: begin
                if (rd_mag < thr33) begin
                    n_state = S_SRD;
                end else if (rdata == '0) begin
                    n_state = S_SING;
                end else begin
                    n_state = S_NRD;
                end
            end
            S_SRD:   n_state = (r_j == n_use) ? S_SING : S_SCHK;
            S_SCHK:  n_state = (rd_mag > thr33) ? S_W1 : S_SRD;
            S_W1:    n_state = S_W2;
            S_W2:    n_state = S_W3;
            S_W3:    n_state = S_W4;
            S_W4:    n_state = (r_k + 1'b1 == two_n) ? S_PRD : S_W1;
            S_NRD:   n_state = S_NDIV;
            S_NDIV:  n_state = S_NWAIT;
            S_NWAIT: begin
                if (div_res.done) begin
                    n_state = (r_k + 1'b1 == two_n) ? S_EROW : S_NRD;
                end
            end
            S_EROW: begin
                if (r_j == n_use) begin
                    n_state = (r_i + 1'b1 == n_use) ? S_ORD : S_PRD;
                end else if (r_j != r_i) begin
                    n_state = S_ERAT;
                end
            end
            S_ERAT:  n_state = S_EK1;
            S_EK1:   n_state = S_EK2;
            S_EK2:   n_state = S_EK3;
            S_EK3:   n_state = S_EK4;
            S_EK4:   n_state = (r_k + 1'b1 == two_n) ? S_EROW : S_EK1;
            S_ORD:   n_state = S_OLAT;
            S_OLAT:  n_state = S_OWAIT;
            S_OWAIT: begin
                if (m_axis_tready) begin
                    n_state = r_m_last ? S_LOAD : S_ORD;
                end
            end
            S_SING:  n_state = S_OWAIT;
            default: n_state = S_LOAD;
        endcase
    end

    // Control registers: state, configuration, counters and flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_LOAD;
            r_size    <= 4'd8;
            r_thr     <= 16'd1;
            r_lc      <= '0;
            r_sat     <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en && i_cfg_index == CFG_MATRIX_SIZE) r_size <= i_cfg_wdata[3:0];
            if (i_cfg_wr_en && i_cfg_index == CFG_PIVOT_THR) r_thr <= i_cfg_wdata;
            case (r_state)
                S_LOAD: begin
                    if (accept) begin
                        if (7'(lc_eff + 7'd1) == total) begin
                            r_lc  <= '0;
                            r_sat <= 1'b0;
                            r_i   <= '0;
                            r_j   <= '0;
                        end else begin
                            r_lc <= 6'(lc_eff + 7'd1);
                        end
                    end
                end
                S_IDENT: begin
                    if (r_j + 1'b1 == n_use) begin
                        r_j <= '0;
                        r_i <= (r_i + 1'b1 == n_use) ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_PCHK: begin
                    r_j <= r_i + 1'b1;
                    r_k <= '0;
                end
                S_SCHK: begin
                    r_found <= r_j;
                    r_j     <= r_j + 1'b1;
                end
                S_W4:    r_k <= r_k + 1'b1;
                S_NWAIT: begin
                    if (div_res.done) begin
                        r_sat <= r_sat | div_res.sat;
                        r_k   <= r_k + 1'b1;
                        r_j   <= '0;
                    end
                end
                S_EROW: begin
                    if (r_j == n_use) begin
                        r_j <= '0;
                        r_i <= (r_i + 1'b1 == n_use) ? '0 : r_i + 1'b1;
                    end else if (r_j == r_i) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_ERAT:  r_k <= '0;
                S_EK3:   r_sat <= r_sat | pq_hi | pq_lo;
                S_EK4: begin
                    r_sat <= r_sat | d_hi | d_lo;
                    r_k   <= r_k + 1'b1;
                    if (r_k + 1'b1 == two_n) r_j <= r_j + 1'b1;
                end
                S_OLAT:  r_m_valid <= 1'b1;
                S_SING:  r_m_valid <= 1'b1;
                S_OWAIT: begin
                    if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                        if (r_j + 1'b1 == n_use) begin
                            r_j <= '0;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end
                end
                default: r_lc <= r_lc;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_PCHK) r_pivot <= rdata;
        if (r_state == S_W2)   r_tmp   <= rdata;
        if (r_state == S_ERAT) r_ratio <= rdata;
        if (r_state == S_EK2)  r_prod  <= $signed(r_ratio) * $signed(rdata);
        if (r_state == S_EK3) begin
            r_pq <= pq_sat;
            r_x  <= rdata;
        end
        if (r_state == S_OLAT) begin
            r_m_data <= {2'b00, r_j[ROW_W-1:0], r_i[ROW_W-1:0], rdata};
            r_m_last <= (r_i + 1'b1 == n_use) && (r_j + 1'b1 == n_use);
            r_m_user <= {r_sat, 1'b0};
        end
        if (r_state == S_SING) begin
            r_m_data <= '0;
            r_m_last <= 1'b1;
            r_m_user <= {r_sat, 1'b1};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = r_m_user;

    // No input item is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input accepted while a result is pending");

    // A singular result is a lone zero item that closes the matrix.
    a_sing_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tlast && m_axis_tdata == '0))
        else $error("singular result malformed");

    // The pivot counter stays inside the matrix during normalization and elimination.
    a_pivot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NWAIT || r_state == S_EK4) |-> (r_i < n_use))
        else $error("pivot index out of range");
endmodule
`default_nettype wire
